// ----- hw/rtl/csb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package csb_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_W     = 32;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic REG_CAPACITY = 1'b0;

    // Operation codes
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_ERASE      = 3'd2,
        OP_READ       = 3'd3,
        OP_INDEX_OF   = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Command transaction payload
    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] value;
        logic [3:0]               index;
        logic [3:0]               position;
    } cmd_item_t;

    // Response transaction payload
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data_out;
        logic [3:0]               index_out;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } rsp_item_t;

    // Ring memory access request
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } mem_req_t;

    // Configuration state seen by the controller
    typedef struct packed {
        logic [COUNT_W-1:0] capacity;
        logic               ptr_clear;
    } cfg_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/csb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface csb_cmd_if;
    logic                 valid;
    logic                 ready;
    csb_pkg::cmd_item_t   item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Response channel
interface csb_rsp_if;
    logic                 valid;
    logic                 ready;
    csb_pkg::rsp_item_t   item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/csb_ring_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csb_ring_mem
(
    input  wire logic                        clk,
    input  wire csb_pkg::mem_req_t           req,
    output logic [csb_pkg::DATA_W-1:0]       rd_data
);

    logic [csb_pkg::DATA_W-1:0] mem [csb_pkg::DEPTH];
    logic [csb_pkg::DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/csb_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csb_cfg
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [csb_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [csb_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [csb_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                     pready,
    input  wire logic [csb_pkg::COUNT_W-1:0]         count,
    output csb_pkg::cfg_state_t                      cfg
);

    logic [csb_pkg::COUNT_W-1:0] capacity_reg;
    logic [csb_pkg::COUNT_W-1:0] capacity_next;
    logic [csb_pkg::COUNT_W-1:0] wr_val;
    logic                        reg_sel;
    logic                        wr_take;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == csb_pkg::REG_CAPACITY);

    // A capacity write only lands while the sequence is empty
    assign wr_take = psel && penable && pwrite && reg_sel && (count == '0);

    // Clamp written value into 1..DEPTH
    always_comb
    begin
        wr_val = pwdata[csb_pkg::COUNT_W-1:0];
        if (wr_val == '0)
        begin
            capacity_next = csb_pkg::COUNT_W'(1);
        end
        else if (wr_val > csb_pkg::COUNT_W'(csb_pkg::DEPTH))
        begin
            capacity_next = csb_pkg::COUNT_W'(csb_pkg::DEPTH);
        end
        else
        begin
            capacity_next = wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= csb_pkg::COUNT_W'(csb_pkg::DEPTH);
        end
        else if (wr_take)
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Read-back
    assign prdata = reg_sel ? csb_pkg::CFG_DATA_W'(capacity_reg) : '0;

    assign cfg.capacity  = capacity_reg;
    assign cfg.ptr_clear = wr_take;

endmodule

`default_nettype wire

// ----- hw/rtl/csb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csb_ctrl
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    csb_cmd_if.sink                            cmd,
    csb_rsp_if.source                          rsp,
    input  wire csb_pkg::cfg_state_t           cfg,
    output csb_pkg::mem_req_t                  mem_req,
    input  wire logic [csb_pkg::DATA_W-1:0]    mem_rd_data,
    output logic [csb_pkg::COUNT_W-1:0]        count
);

    localparam int SW = csb_pkg::SLOT_W;
    localparam int CW = csb_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_ERASE_HEAD,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                      state_reg,  state_next;
    logic [2:0]                  op_reg,     op_next;
    logic [csb_pkg::DATA_W-1:0]  val_reg,    val_next;
    logic [3:0]                  idx_reg,    idx_next;
    logic [3:0]                  pos_reg,    pos_next;
    logic [SW-1:0]               head_reg,   head_next;
    logic [SW-1:0]               tail_reg,   tail_next;
    logic [CW-1:0]               count_reg,  count_next;
    logic [3:0]                  cur_reg,    cur_next;
    logic [1:0]                  status_reg, status_next;
    logic [csb_pkg::DATA_W-1:0]  data_reg,   data_next;
    logic [3:0]                  ixo_reg,    ixo_next;
    logic                        out_valid_reg, out_valid_next;
    csb_pkg::rsp_item_t          out_item_reg,  out_item_next;

    logic [CW-1:0]               cap;
    logic [SW-1:0]               cap_m1;

    // Physical slot of a logical offset from head, modulo capacity
    function automatic logic [SW-1:0] ring_slot(input logic [SW-1:0] base,
                                                input logic [CW-1:0] offs,
                                                input logic [CW-1:0] capv);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(offs);
        if (sum >= (CW+1)'(capv))
        begin
            sum = sum - (CW+1)'(capv);
        end
        return sum[SW-1:0];
    endfunction

    assign cap    = cfg.capacity;
    assign cap_m1 = SW'(cap - CW'(1));

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;
    assign count     = count_reg;

    // Sequencer: erase reads one entry ahead of the write, so a read never
    // hits a slot that is still waiting to be written.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        ixo_next       = ixo_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        mem_req        = '0;

        // Output register drains independently
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next     = cmd.item.operation;
                    val_next    = cmd.item.value;
                    idx_next    = cmd.item.index;
                    pos_next    = cmd.item.position;
                    status_next = csb_pkg::ST_OK;
                    data_next   = '0;
                    ixo_next    = '0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    csb_pkg::OP_PUSH_BACK:
                    begin
                        if (count_reg >= cap)
                        begin
                            status_next = csb_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = tail_reg;
                            mem_req.wr_data = val_reg;
                            tail_next       = ring_slot(tail_reg, CW'(1), cap);
                            count_next      = count_reg + CW'(1);
                        end
                    end
                    csb_pkg::OP_PUSH_FRONT:
                    begin
                        if (count_reg >= cap)
                        begin
                            status_next = csb_pkg::ST_FULL;
                        end
                        else
                        begin
                            head_next       = (head_reg == '0) ? cap_m1
                                                               : head_reg - SW'(1);
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = head_next;
                            mem_req.wr_data = val_reg;
                            count_next      = count_reg + CW'(1);
                        end
                    end
                    csb_pkg::OP_ERASE, csb_pkg::OP_READ:
                    begin
                        if (CW'(idx_reg) >= count_reg)
                        begin
                            status_next = csb_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = ring_slot(head_reg, CW'(idx_reg), cap);
                            state_next      = (op_reg == csb_pkg::OP_ERASE)
                                              ? S_ERASE_HEAD : S_RDATA;
                        end
                    end
                    csb_pkg::OP_INDEX_OF:
                    begin
                        if (CW'(pos_reg) >= cap)
                        begin
                            status_next = csb_pkg::ST_RANGE;
                        end
                        else if (pos_reg >= head_reg)
                        begin
                            ixo_next = pos_reg - head_reg;
                        end
                        else
                        begin
                            ixo_next = 4'(cap - CW'(head_reg) + CW'(pos_reg));
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_RDATA:
            begin
                data_next  = mem_rd_data;
                state_next = S_DONE;
            end

            // Capture the erased value, start the shift if anything follows, else shrink the ring
            S_ERASE_HEAD:
            begin
                data_next = mem_rd_data;
                if (CW'(idx_reg) + CW'(1) < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ring_slot(head_reg, CW'(idx_reg) + CW'(1), cap);
                    cur_next        = idx_reg;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    tail_next  = (tail_reg == '0) ? cap_m1 : tail_reg - SW'(1);
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            // Move entry cur+1 down into cur, prefetch cur+2
            S_SHIFT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ring_slot(head_reg, CW'(cur_reg), cap);
                mem_req.wr_data = mem_rd_data;
                if (CW'(cur_reg) + CW'(2) < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ring_slot(head_reg, CW'(cur_reg) + CW'(2), cap);
                    cur_next        = cur_reg + 4'd1;
                end
                else
                begin
                    tail_next  = (tail_reg == '0) ? cap_m1 : tail_reg - SW'(1);
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.status    = status_reg;
                    out_item_next.data_out  = data_reg;
                    out_item_next.index_out = ixo_reg;
                    out_item_next.count     = count_reg;
                    out_item_next.is_empty  = (count_reg == '0);
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Capacity change rewinds the ring pointers
        if (cfg.ptr_clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            val_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            status_reg    <= '0;
            data_reg      <= '0;
            ixo_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            status_reg    <= status_next;
            data_reg      <= data_next;
            ixo_reg       <= ixo_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/circular_sequence_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role      Handshake          Payload
// cmd       sink      valid/ready        operation, value, index, position
// rsp       source    valid/ready        status, data_out, index_out, count, is_empty
// apb       slave     psel/penable       capacity_in_use at byte address 0
//
// Insert, index-of and unknown codes pass through execute and done; read adds
// a read-data step. A read or erase with an index out of range skips to done.
// Erase captures the erased value, then shifts each entry behind it down one slot
// in a shift loop that moves one entry per cycle through the ring memory.
// Reset is immediate; the ring memory has no clearing pass.
// A finished result waits in the output register while the next command is
// taken; a stalled response only holds the sequencer at its final step.

module circular_sequence_buffer
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    csb_cmd_if.sink                                  cmd,
    csb_rsp_if.source                                rsp,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [csb_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [csb_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [csb_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                     pready
);

    csb_pkg::cfg_state_t             cfg;
    csb_pkg::mem_req_t               mem_req;
    logic [csb_pkg::DATA_W-1:0]      mem_rd_data;
    logic [csb_pkg::COUNT_W-1:0]     count;

    csb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .count   (count),
        .cfg     (cfg)
    );

    csb_ring_mem u_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    csb_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .cfg         (cfg),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .count       (count)
    );

    // Element count never exceeds the capacity in use
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count <= cfg.capacity)
        else $error("element count above capacity");

    // A full status is only reported when the ring is at capacity
    a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.item.status == csb_pkg::ST_FULL))
            |-> (rsp.item.count == cfg.capacity))
        else $error("full status below capacity");

    // The shift loop never reads the slot it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("ring memory read and write collide");

    // One command in flight: ready drops after every accepted command
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command taken while busy");

endmodule

`default_nettype wire
